@@ hw/rtl/upe_pkg.sv @@
package upe_pkg;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_DROP    = 2'd2
  } kind_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        start_of_frame;
    logic [15:0] frame_len;
    logic [15:0] link_type;
    logic [31:0] frame_number;
    logic [63:0] timestamp_ns;
  } in_word_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  payload_byte;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [31:0] frame_id;
    logic [63:0] time_ns;
    logic        last;
    logic [31:0] fragments_seen;
  } out_word_t;

  localparam logic [15:0] LINK_NULL     = 16'd0;
  localparam logic [15:0] LINK_LOOP     = 16'd108;
  localparam logic [15:0] LINK_ETHERNET = 16'd1;
  localparam logic [15:0] LINK_RAW      = 16'd101;
  localparam logic [15:0] LINK_IPV4     = 16'd228;

  localparam logic [3:0]  LOOP_HDR_LEN  = 4'd4;
  localparam logic [3:0]  ETH_HDR_LEN   = 4'd14;
  localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
  localparam logic [31:0] AF_INET_BE    = 32'h0000_0002;
  localparam logic [31:0] AF_INET_LE    = 32'h0200_0000;
  localparam logic [7:0]  PROTO_UDP     = 8'd17;
  localparam logic [3:0]  IP_VERSION    = 4'd4;
  localparam logic [5:0]  IP_MIN_HDR    = 6'd20;
  localparam logic [5:0]  UDP_HDR_LEN   = 6'd8;

endpackage

@@ hw/rtl/ipv4_udp_payload_extractor.sv @@
// A result word enters the queue as its byte is taken and shows on result at the queue head.
// Throughput: one frame byte per cycle while full is low; each byte is parsed combinationally.
// The result queue (QUEUE_DEPTH words) lets input continue while results wait to be popped.
// full is high whenever the queue holds QUEUE_DEPTH words, even in a cycle with a pop.
// Reset (synchronous): parser state and fragment count clear, queue empties.
module ipv4_udp_payload_extractor #(
  parameter int MAX_FRAME_LEN = 65535,
  parameter int QUEUE_DEPTH   = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  upe_pkg::in_word_t  item,
  output logic               empty,
  input  logic               pop,
  output upe_pkg::out_word_t result
);
  import upe_pkg::*;

  logic      accept;
  logic      res_valid;
  out_word_t res;

  assign accept = push && !full;

  upe_parse #(.MAX_FRAME_LEN(MAX_FRAME_LEN)) u_parse (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  upe_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (accept && res_valid),
    .wr_data (res),
    .full    (full),
    .rd_en   (pop),
    .empty   (empty),
    .rd_data (result)
  );

endmodule

@@ hw/rtl/upe_parse.sv @@
module upe_parse #(
  parameter int MAX_FRAME_LEN = 65535
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  upe_pkg::in_word_t item,
  output logic              res_valid,
  output upe_pkg::out_word_t res
);
  import upe_pkg::*;

  logic [15:0] byte_position, byte_position_next;
  logic [3:0]  link_offset, link_offset_next;
  logic [31:0] loop_word, loop_word_next;
  logic [5:0]  ip_header_bytes, ip_header_bytes_next;
  logic [15:0] ip_total_length, ip_total_length_next;
  logic [15:0] frag_word, frag_word_next;
  logic [15:0] source_port, source_port_next;
  logic [15:0] dest_port, dest_port_next;
  logic [15:0] udp_length, udp_length_next;
  logic [15:0] payload_remaining, payload_remaining_next;
  logic        frame_rejected, frame_rejected_next;
  logic [31:0] fragment_total, fragment_total_next;
  logic [15:0] held_len, held_len_next;
  logic [15:0] held_link, held_link_next;
  logic [31:0] held_number, held_number_next;
  logic [63:0] held_time, held_time_next;

  logic        sof;
  logic [7:0]  b;
  logic [15:0] c_pos, rel;
  logic [31:0] lw_shift;
  logic [5:0]  hb_new;
  logic [16:0] lit, start, room, want;
  logic [15:0] hb_end;
  logic [2:0]  k;

  always_comb begin
    sof = item.start_of_frame;
    b   = item.data_byte;

    held_len_next        = sof ? item.frame_len    : held_len;
    held_link_next       = sof ? item.link_type    : held_link;
    held_number_next     = sof ? item.frame_number : held_number;
    held_time_next       = sof ? item.timestamp_ns : held_time;
    c_pos                = sof ? 16'd0 : byte_position;
    loop_word_next       = sof ? 32'd0 : loop_word;
    ip_header_bytes_next = sof ? 6'd0  : ip_header_bytes;
    ip_total_length_next = sof ? 16'd0 : ip_total_length;
    frag_word_next       = sof ? 16'd0 : frag_word;
    source_port_next     = sof ? 16'd0 : source_port;
    dest_port_next       = sof ? 16'd0 : dest_port;
    udp_length_next      = sof ? 16'd0 : udp_length;
    payload_remaining_next = sof ? 16'd0 : payload_remaining;
    link_offset_next     = link_offset;
    frame_rejected_next  = frame_rejected;
    if (sof) begin
      frame_rejected_next = 1'b0;
      if (item.link_type == LINK_NULL || item.link_type == LINK_LOOP) begin
        link_offset_next = LOOP_HDR_LEN;
      end else if (item.link_type == LINK_ETHERNET) begin
        link_offset_next = ETH_HDR_LEN;
      end else if (item.link_type == LINK_RAW || item.link_type == LINK_IPV4) begin
        link_offset_next = 4'd0;
      end else begin
        link_offset_next = 4'd0;
        frame_rejected_next = 1'b1;
      end
      if ({1'b0, item.frame_len} > 17'(MAX_FRAME_LEN) ||
          17'(link_offset_next) + 17'd20 > {1'b0, item.frame_len}) begin
        frame_rejected_next = 1'b1;
      end
    end

    byte_position_next  = (c_pos != 16'hFFFF) ? c_pos + 16'd1 : c_pos;
    fragment_total_next = fragment_total;

    rel      = c_pos - {12'd0, link_offset_next};
    lw_shift = {loop_word_next[23:0], b};
    hb_new   = {b[3:0], 2'b00};
    hb_end   = {10'd0, ip_header_bytes_next} + 16'(UDP_HDR_LEN);
    k        = 3'(rel - {10'd0, ip_header_bytes_next});
    lit      = 17'(link_offset_next) + {1'b0, ip_total_length_next};
    start    = 17'(link_offset_next) + 17'(ip_header_bytes_next) + 17'(UDP_HDR_LEN);
    room     = (lit <= {1'b0, held_len_next}) ? lit - start
                                               : {1'b0, held_len_next} - start;
    want     = {1'b0, udp_length_next} - 17'(UDP_HDR_LEN);
    if (want > room) begin
      want = room;
    end

    res_valid          = 1'b0;
    res.kind           = KIND_PAYLOAD;
    res.payload_byte   = 8'd0;
    res.src_port       = source_port_next;
    res.dst_port       = dest_port_next;
    res.frame_id       = held_number_next;
    res.time_ns        = held_time_next;
    res.last           = 1'b0;

    if (!frame_rejected_next && c_pos < held_len_next) begin
      if (payload_remaining_next != 16'd0) begin
        payload_remaining_next = payload_remaining_next - 16'd1;
        res_valid        = 1'b1;
        res.payload_byte = b;
        res.last         = (payload_remaining_next == 16'd0);
        if (payload_remaining_next == 16'd0) begin
          frame_rejected_next = 1'b1;
        end
      end else if (c_pos < {12'd0, link_offset_next}) begin
        loop_word_next = lw_shift;
        if (link_offset_next == LOOP_HDR_LEN && c_pos == 16'd3 &&
            lw_shift != AF_INET_BE && lw_shift != AF_INET_LE) begin
          frame_rejected_next = 1'b1;
        end
        if (link_offset_next == ETH_HDR_LEN && c_pos == 16'd13 &&
            lw_shift[15:0] != ETH_TYPE_IPV4) begin
          frame_rejected_next = 1'b1;
        end
      end else if (rel == 16'd0) begin
        ip_header_bytes_next = hb_new;
        if (b[7:4] != IP_VERSION || hb_new < IP_MIN_HDR ||
            17'(link_offset_next) + 17'(hb_new) > {1'b0, held_len_next}) begin
          frame_rejected_next = 1'b1;
        end
      end else if (rel == 16'd2 || rel == 16'd3) begin
        ip_total_length_next = {ip_total_length_next[7:0], b};
      end else if (rel == 16'd6 || rel == 16'd7) begin
        frag_word_next = {frag_word_next[7:0], b};
      end else if (rel == 16'd9) begin
        if (b != PROTO_UDP) begin
          frame_rejected_next = 1'b1;
        end else if (frag_word_next[13:0] != 14'd0) begin
          if (fragment_total != 32'hFFFF_FFFF) begin
            fragment_total_next = fragment_total + 32'd1;
          end
          frame_rejected_next = 1'b1;
          res_valid    = 1'b1;
          res.kind     = KIND_DROP;
          res.src_port = 16'd0;
          res.dst_port = 16'd0;
        end
      end else if (rel >= {10'd0, ip_header_bytes_next} && rel < hb_end) begin
        case (k)
          3'd0, 3'd1: source_port_next = {source_port_next[7:0], b};
          3'd2, 3'd3: dest_port_next   = {dest_port_next[7:0], b};
          3'd4, 3'd5: udp_length_next  = {udp_length_next[7:0], b};
          3'd7: begin
            if (udp_length_next < 16'(UDP_HDR_LEN) ||
                ip_total_length_next < hb_end) begin
              frame_rejected_next = 1'b1;
            end else if (want == 17'd0) begin
              frame_rejected_next = 1'b1;
              res_valid = 1'b1;
              res.kind  = KIND_EMPTY;
              res.last  = 1'b1;
            end else begin
              payload_remaining_next = want[15:0];
            end
          end
          default: ;
        endcase
      end
    end
    res.fragments_seen = fragment_total_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position     <= '0;
      link_offset       <= '0;
      loop_word         <= '0;
      ip_header_bytes   <= '0;
      ip_total_length   <= '0;
      frag_word         <= '0;
      source_port       <= '0;
      dest_port         <= '0;
      udp_length        <= '0;
      payload_remaining <= '0;
      frame_rejected    <= 1'b0;
      fragment_total    <= '0;
      held_len          <= '0;
      held_link         <= '0;
      held_number       <= '0;
      held_time         <= '0;
    end else if (accept) begin
      byte_position     <= byte_position_next;
      link_offset       <= link_offset_next;
      loop_word         <= loop_word_next;
      ip_header_bytes   <= ip_header_bytes_next;
      ip_total_length   <= ip_total_length_next;
      frag_word         <= frag_word_next;
      source_port       <= source_port_next;
      dest_port         <= dest_port_next;
      udp_length        <= udp_length_next;
      payload_remaining <= payload_remaining_next;
      frame_rejected    <= frame_rejected_next;
      fragment_total    <= fragment_total_next;
      held_len          <= held_len_next;
      held_link         <= held_link_next;
      held_number       <= held_number_next;
      held_time         <= held_time_next;
    end
  end

endmodule

@@ hw/rtl/upe_fifo.sv @@
module upe_fifo #(
  parameter int DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  upe_pkg::out_word_t wr_data,
  output logic               full,
  input  logic               rd_en,
  output logic               empty,
  output upe_pkg::out_word_t rd_data
);
  import upe_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  out_word_t   store [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [AW:0]   count;
  logic          do_wr, do_rd;

  assign full    = (count == (AW+1)'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = store[rd_ptr];
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      store[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ hw/rtl/upe_check.sv @@
module upe_check (
  input logic               clk,
  input logic               rst,
  input logic               push,
  input logic               full,
  input logic               pop,
  input logic               empty,
  input upe_pkg::out_word_t result
);
  import upe_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queue not empty after reset");

  a_drop_counted: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.kind == KIND_DROP) |->
      (result.fragments_seen != 32'd0 && result.src_port == 16'd0 &&
       result.dst_port == 16'd0 && !result.last))
    else $error("bad fragment drop word");

  a_empty_marker: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.kind == KIND_EMPTY) |-> (result.last && result.payload_byte == 8'd0))
    else $error("empty marker malformed");

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    (empty && !push) |=> empty)
    else $error("word appeared without input");

endmodule

bind ipv4_udp_payload_extractor upe_check u_check (.*);

@@ bench/upe_checker.sv @@
`timescale 1ns / 100ps

module upe_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic               full,
  input  upe_pkg::in_word_t  item,
  input  logic               empty,
  input  logic               pop,
  input  upe_pkg::out_word_t result,
  output int                 errors,
  output int                 pending,
  output int                 n_payload,
  output int                 n_empty,
  output int                 n_drop
);
  import upe_pkg::*;

  logic [15:0] byte_pos, ip_total, frag, sport, dport, udp_len, remaining;
  logic [15:0] held_len, held_link;
  logic [3:0]  link_off;
  logic [31:0] family, frag_count, held_num;
  logic [15:0] eth_type;
  logic [5:0]  hdr_bytes;
  logic        rejected;
  logic [63:0] held_ts;
  out_word_t   expected_words[$];

  task automatic emit(input kind_t k, input logic [7:0] b, input logic [15:0] sp,
                      input logic [15:0] dp, input logic lst);
    out_word_t w;
    w.kind = k;
    w.payload_byte = b;
    w.src_port = sp;
    w.dst_port = dp;
    w.frame_id = held_num;
    w.time_ns = held_ts;
    w.last = lst;
    w.fragments_seen = frag_count;
    expected_words = {expected_words, w};
  endtask

  task automatic parse_byte(input in_word_t w);
    int pos, rel, hb, flen, start, want, room, k;
    logic [7:0] b;
    b = w.data_byte;
    if (w.start_of_frame) begin
      held_len = w.frame_len;
      held_link = w.link_type;
      held_num = w.frame_number;
      held_ts = w.timestamp_ns;
      byte_pos = 0; family = 0; eth_type = 0; hdr_bytes = 0; ip_total = 0; frag = 0;
      sport = 0; dport = 0; udp_len = 0; remaining = 0; rejected = 0;
      if (held_link == LINK_NULL || held_link == LINK_LOOP) link_off = LOOP_HDR_LEN;
      else if (held_link == LINK_ETHERNET) link_off = ETH_HDR_LEN;
      else if (held_link == LINK_RAW || held_link == LINK_IPV4) link_off = 0;
      else begin
        link_off = 0;
        rejected = 1;
      end
      if (int'(link_off) + 20 > int'(held_len)) rejected = 1;
    end
    pos = byte_pos;
    if (byte_pos != 16'hFFFF) byte_pos++;
    flen = held_len;
    if (rejected || pos >= flen) return;
    if (remaining != 0) begin
      remaining--;
      if (remaining == 0) rejected = 1;
      emit(KIND_PAYLOAD, b, sport, dport, remaining == 0);
      return;
    end
    if (pos < link_off) begin
      family = {family[23:0], b};
      eth_type = {eth_type[7:0], b};
      if (link_off == LOOP_HDR_LEN && pos == 3 && family != AF_INET_BE && family != AF_INET_LE)
        rejected = 1;
      if (link_off == ETH_HDR_LEN && pos == 13 && eth_type != ETH_TYPE_IPV4) rejected = 1;
      return;
    end
    rel = pos - link_off;
    hb = hdr_bytes;
    if (rel == 0) begin
      hb = b[3:0] * 4;
      hdr_bytes = 6'(hb);
      if (b[7:4] != IP_VERSION || hb < IP_MIN_HDR || link_off + hb > flen) rejected = 1;
      return;
    end
    if (rel == 2 || rel == 3) begin
      ip_total = {ip_total[7:0], b};
      return;
    end
    if (rel == 6 || rel == 7) begin
      frag = {frag[7:0], b};
      return;
    end
    if (rel == 9) begin
      if (b != PROTO_UDP) begin
        rejected = 1;
        return;
      end
      if (frag[12:0] != 0 || frag[13]) begin
        if (frag_count != '1) frag_count++;
        rejected = 1;
        emit(KIND_DROP, 8'd0, 16'd0, 16'd0, 1'b0);
      end
      return;
    end
    if (rel >= hb && rel < hb + 8) begin
      k = rel - hb;
      if (k < 2) sport = {sport[7:0], b};
      else if (k < 4) dport = {dport[7:0], b};
      else if (k < 6) udp_len = {udp_len[7:0], b};
      else if (k == 7) begin
        start = link_off + hb + 8;
        if (udp_len < 8 || ip_total < hb + 8) begin
          rejected = 1;
          return;
        end
        want = udp_len - 8;
        if (link_off + ip_total <= flen) room = link_off + ip_total - start;
        else room = flen - start;
        if (want > room) want = room;
        if (want == 0) begin
          rejected = 1;
          emit(KIND_EMPTY, 8'd0, sport, dport, 1'b1);
          return;
        end
        remaining = 16'(want);
      end
    end
  endtask

  task automatic compare(input out_word_t got);
    out_word_t exp;
    if (expected_words.size() == 0) begin
      $error("unexpected result word %h", got);
      errors++;
      return;
    end
    exp = expected_words.pop_front();
    if (got.kind !== exp.kind) begin
      $error("kind: expected %0d, got %0d", exp.kind, got.kind); errors++;
    end
    if (got.payload_byte !== exp.payload_byte) begin
      $error("payload_byte: expected %h, got %h", exp.payload_byte, got.payload_byte); errors++;
    end
    if (got.src_port !== exp.src_port) begin
      $error("src_port: expected %h, got %h", exp.src_port, got.src_port); errors++;
    end
    if (got.dst_port !== exp.dst_port) begin
      $error("dst_port: expected %h, got %h", exp.dst_port, got.dst_port); errors++;
    end
    if (got.frame_id !== exp.frame_id) begin
      $error("frame_id: expected %h, got %h", exp.frame_id, got.frame_id); errors++;
    end
    if (got.time_ns !== exp.time_ns) begin
      $error("time_ns: expected %h, got %h", exp.time_ns, got.time_ns); errors++;
    end
    if (got.last !== exp.last) begin
      $error("last: expected %b, got %b", exp.last, got.last); errors++;
    end
    if (got.fragments_seen !== exp.fragments_seen) begin
      $error("fragments_seen: expected %h, got %h", exp.fragments_seen, got.fragments_seen);
      errors++;
    end
    case (exp.kind)
      KIND_PAYLOAD: n_payload++;
      KIND_EMPTY:   n_empty++;
      default:      n_drop++;
    endcase
  endtask

  initial begin
    errors = 0; n_payload = 0; n_empty = 0; n_drop = 0; pending = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      byte_pos <= 0; link_off <= 0; family <= 0; eth_type <= 0; hdr_bytes <= 0;
      ip_total <= 0; frag <= 0; sport <= 0; dport <= 0; udp_len <= 0; remaining <= 0;
      rejected <= 0; frag_count <= 0; held_len <= 0; held_link <= 0; held_num <= 0;
      held_ts <= 0;
      expected_words.delete();
      pending = 0;
    end else begin
      if (pop && !empty) compare(result);
      if (push && !full) parse_byte(item);
      pending = expected_words.size();
    end
  end
endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import upe_pkg::*;

  logic      clk = 0;
  logic      rst = 1;
  logic      push = 0;
  logic      pop = 0;
  logic      full, empty;
  in_word_t  item = '0;
  out_word_t result;
  int        errors, pending, n_payload, n_empty, n_drop;
  int        words_sent = 0;
  logic [7:0] frame_buf[$];

  always #6 clk = ~clk;

  ipv4_udp_payload_extractor dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .item(item),
    .empty(empty), .pop(pop), .result(result)
  );

  upe_checker chk (
    .clk(clk), .rst(rst), .push(push), .full(full), .item(item), .empty(empty),
    .pop(pop), .result(result), .errors(errors), .pending(pending),
    .n_payload(n_payload), .n_empty(n_empty), .n_drop(n_drop)
  );

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // sends one word; gaps only when the caller allows them; push stays high after
  task automatic send(input in_word_t w, input bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      push <= 0;
      repeat (g) @(posedge clk);
    end
    push <= 1;
    item <= w;
    @(posedge clk);
    while (full) @(posedge clk);
    words_sent++;
  endtask

  task automatic add_byte(input logic [7:0] v);
    frame_buf = {frame_buf, v};
  endtask

  task automatic build_frame(input logic [15:0] link, input int kind_sel);
    int ploff, hl, plen, udpl, totl, i;
    logic [15:0] fr;
    frame_buf.delete();
    if (link == LINK_NULL || link == LINK_LOOP) begin
      if ($urandom_range(0, 1)) frame_buf = {8'h02, 8'h00, 8'h00, 8'h00};
      else frame_buf = {8'h00, 8'h00, 8'h00, 8'h02};
      if (kind_sel == 9) frame_buf[$urandom_range(0, 3)] ^= 8'h10;
    end else if (link == LINK_ETHERNET) begin
      for (i = 0; i < 12; i++) add_byte(8'($urandom));
      add_byte(kind_sel == 9 ? 8'h86 : 8'h08);
      add_byte(8'h00);
    end
    ploff = frame_buf.size();
    hl = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 7) : 5;
    plen = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
    udpl = plen + 8;
    if (kind_sel == 5) udpl = $urandom_range(0, 7);
    if (kind_sel == 6) udpl = plen + 8 + $urandom_range(1, 5);
    totl = hl * 4 + 8 + plen;
    if (kind_sel == 7) totl = hl * 4 + $urandom_range(0, 7);
    if (kind_sel == 8) totl = totl - $urandom_range(0, plen);
    fr = 16'h4000 & {16{$urandom_range(0, 1) == 1}};
    if (kind_sel == 2) fr |= 16'h2000;
    if (kind_sel == 3) fr |= 16'($urandom_range(1, 16'h1FFF));
    add_byte(kind_sel == 4 ? {4'($urandom_range(0, 15)), 4'(hl)} : {IP_VERSION, 4'(hl)});
    add_byte(8'($urandom));
    add_byte(totl[15:8]);
    add_byte(totl[7:0]);
    add_byte(8'($urandom));
    add_byte(8'($urandom));
    add_byte(fr[15:8]);
    add_byte(fr[7:0]);
    add_byte(8'($urandom));
    add_byte(kind_sel == 10 ? 8'd6 : PROTO_UDP);
    for (i = 10; i < hl * 4; i++) add_byte(8'($urandom));
    add_byte(8'($urandom));
    add_byte(8'($urandom));
    add_byte(8'($urandom));
    add_byte(8'($urandom));
    add_byte(udpl[15:8]);
    add_byte(udpl[7:0]);
    add_byte(8'($urandom));
    add_byte(8'($urandom));
    for (i = 0; i < plen; i++) add_byte(8'($urandom));
    if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 4)) add_byte(8'($urandom));
  endtask

  // len_mode: 0 exact, 1 truncated capture, 2 random length field
  task automatic send_frame(input logic [15:0] link, input int len_mode, input int cut,
                            input bit gaps);
    in_word_t w;
    int n, i;
    n = frame_buf.size();
    w.link_type = link;
    w.frame_number = 32'({$urandom, $urandom} >> $urandom_range(0, 31));
    w.timestamp_ns = {$urandom, $urandom};
    case (len_mode)
      0: w.frame_len = 16'(n);
      1: w.frame_len = 16'($urandom_range(1, n));
      default: w.frame_len = 16'($urandom_range(1, 16'hFFFF));
    endcase
    if (cut > 0 && cut < n) n = cut;
    for (i = 0; i < n; i++) begin
      w.data_byte = frame_buf[i];
      w.start_of_frame = (i == 0);
      send(w, gaps);
    end
  endtask

  function automatic logic [15:0] pick_link();
    case ($urandom_range(0, 5))
      0: return LINK_NULL;
      1: return LINK_LOOP;
      2: return LINK_ETHERNET;
      3: return LINK_RAW;
      default: return LINK_IPV4;
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      pop <= 0;
    end else if ($urandom_range(0, 99) < 3) begin
      pop <= 0;
    end else begin
      pop <= ($urandom_range(0, 9) < 7);
    end
  end

  initial begin
    in_word_t w;
    int k, sel;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // stray words before any start with a walking one on the data byte, then rejected starts
    for (k = 0; k < 6; k++) begin
      w = '0;
      w.data_byte = 8'h80 >> k;
      w.frame_len = 16'hFFFF;
      w.link_type = 16'hFFFF;
      w.frame_number = '1;
      w.timestamp_ns = '1;
      send(w, 0);
    end
    w = '0;
    w.start_of_frame = 1;
    w.link_type = 16'h1234;
    w.frame_len = 16'hFFFF;
    send(w, 0);
    w.link_type = LINK_IPV4;
    w.frame_len = 16'd1;
    send(w, 0);
    w.frame_len = 16'd19;
    send(w, 0);

    // each link type, one frame kind per link type
    build_frame(LINK_NULL, 0);   send_frame(LINK_NULL, 0, 0, 0);
    build_frame(LINK_ETHERNET, 2); send_frame(LINK_ETHERNET, 0, 0, 0);
    build_frame(LINK_RAW, 3);   send_frame(LINK_RAW, 0, 0, 0);
    build_frame(LINK_LOOP, 9);  send_frame(LINK_LOOP, 0, 0, 0);
    build_frame(LINK_IPV4, 8);  send_frame(LINK_IPV4, 0, 30, 0);

    // pause until the pipe drains
    push <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);

    while (words_sent < 700) begin
      sel = $urandom_range(0, 99);
      if (sel < 60) sel = 0;
      else sel = $urandom_range(1, 10);
      build_frame(pick_link(), sel);
      k = $urandom_range(0, 19);
      send_frame(pick_link() == LINK_ETHERNET && k == 0 ? 16'($urandom) : w.link_type,
                 0, 0, 1);
      // above frame may be sent with a link type other than it was built for; main traffic below
      build_frame(w.link_type, sel);
      send_frame(w.link_type, k < 15 ? 0 : (k < 18 ? 1 : 2),
                 k == 19 ? $urandom_range(1, frame_buf.size()) : 0, 1);
      w.link_type = pick_link();
      if (words_sent > 400 && words_sent < 460) begin
        push <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
    end

    push <= 0;
    @(posedge clk);
    k = 0;
    while (pending != 0 && k < 100000) begin
      @(posedge clk);
      k++;
    end
    repeat (20) @(posedge clk);
    $display("sent %0d frame bytes: %0d payload, %0d empty, %0d fragment results checked",
             words_sent, n_payload, n_empty, n_drop);
    if (errors == 0 && pending == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("testbench failed");
    $finish;
  end
endmodule

@@ files.f @@
hw/rtl/upe_pkg.sv
hw/rtl/upe_parse.sv
hw/rtl/upe_fifo.sv
hw/rtl/ipv4_udp_payload_extractor.sv
hw/rtl/upe_check.sv
bench/upe_checker.sv
bench/testbench.sv
